[rtl/core/min_buffer_queue_counter_macros.svh]
// Assertion macros shared by the checker of the minimum buffer queue counter
`ifndef MIN_BUFFER_QUEUE_COUNTER_MACROS_SVH
`define MIN_BUFFER_QUEUE_COUNTER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted
`define MBQC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is asserted
`define MBQC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after a reset cycle
`define MBQC_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mbqc_pkg.sv]
// Shared constants, state type and control structs of the minimum buffer queue counter
package mbqc_pkg;

  // Default number of buffer queues
  localparam int DEF_MAX_QUEUES = 64;

  // Field widths of the item and result
  localparam int TRAIN_W     = 16;
  localparam int QIDX_W      = 6;
  localparam int QUSED_W     = 7;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_PAD_W   = OUT_TDATA_W - QIDX_W - QUSED_W;

  // Bit positions of the result fields in out_tdata
  localparam int QIDX_LSB  = 0;
  localparam int QUSED_LSB = QIDX_W;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_WRITE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // latch item, read tail of the last queue in use
    logic check;   // decide new queue or start search
    logic step;    // one binary search step
    logic finish;  // write tail back, present result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic search_done;  // queue index settled
    logic slot_free;    // result register can take a new result
  } sts_t;

endpackage

[rtl/core/min_buffer_queue_counter.sv]
// Top level of the minimum buffer queue counter
// Places each train number in the first buffer queue whose tail is not above it, found by
// binary search over the queue tails, or opens a new queue; reports the queue index, the
// number of queues in use and an overflow flag when every queue is taken (item dropped).
// An item marked last clears the count after its result. One item is worked at a time; a new
// queue opens straight from the check, while a search reads the single tail memory once per
// search step. A result waiting on out_tready delays only the write-back of the next item.
module min_buffer_queue_counter #(
  parameter int MAX_QUEUES = mbqc_pkg::DEF_MAX_QUEUES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [mbqc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] train_number
  input  logic                             in_tlast,   // last_item
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [mbqc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [5:0] queue_index, [12:6] queues_used
  output logic                             out_tuser   // overflow
);

  mbqc_pkg::cmd_t cmd;
  mbqc_pkg::sts_t sts;

  mbqc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbqc_dp #(
    .MAX_QUEUES (MAX_QUEUES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/mbqc_dp.sv]
// Datapath: tail memory, binary search bounds, queue count and result register
module mbqc_dp #(
  parameter int MAX_QUEUES = mbqc_pkg::DEF_MAX_QUEUES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [mbqc_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                               in_tlast,
  input  mbqc_pkg::cmd_t                     cmd,
  output mbqc_pkg::sts_t                     sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [mbqc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser
);

  localparam int IDX_W = $clog2(MAX_QUEUES);
  localparam int CNT_W = $clog2(MAX_QUEUES + 1);
  localparam logic [CNT_W-1:0] MAXQ = CNT_W'(MAX_QUEUES);

  // Tail memory
  logic [mbqc_pkg::TRAIN_W-1:0] mem [MAX_QUEUES];
  logic [mbqc_pkg::TRAIN_W-1:0] rd_data_r;
  logic [IDX_W-1:0]             rd_addr;
  logic                         rd_en;

  // Item and search registers
  logic [mbqc_pkg::TRAIN_W-1:0] item_r;
  logic                         last_r;
  logic [CNT_W-1:0]             used_r;
  logic [CNT_W-1:0]             used_count_r;
  logic [IDX_W-1:0]             lo_r;
  logic [IDX_W-1:0]             hi_r;
  logic [IDX_W-1:0]             mid_r;
  logic                         ovf_r;

  // Result register
  logic                         out_valid_r;
  logic [mbqc_pkg::QIDX_W-1:0]  out_idx_r;
  logic [mbqc_pkg::QUSED_W-1:0] out_used_r;
  logic                         out_ovf_r;

  // Search arithmetic
  logic             tail_gt;
  logic             need_new;
  logic             full;
  logic [IDX_W-1:0] chk_hi;
  logic [IDX_W-1:0] step_lo;
  logic [IDX_W-1:0] step_hi;
  logic [IDX_W-1:0] nlo;
  logic [IDX_W-1:0] nhi;
  logic [IDX_W:0]   mid_sum;
  logic [IDX_W-1:0] nmid;

  always_comb begin
    tail_gt  = rd_data_r > item_r;
    need_new = (used_r == '0) || tail_gt;
    full     = used_r == MAXQ;
    chk_hi   = IDX_W'(used_r - CNT_W'(1));
    step_lo  = tail_gt ? IDX_W'(mid_r + IDX_W'(1)) : lo_r;
    step_hi  = tail_gt ? hi_r : mid_r;
    if (cmd.check) begin
      nlo = '0;
      nhi = chk_hi;
    end else begin
      nlo = step_lo;
      nhi = step_hi;
    end
    mid_sum = {1'b0, nlo} + {1'b0, nhi};
    nmid    = mid_sum[IDX_W:1];
  end

  assign sts.search_done = (cmd.check && need_new) || (nlo >= nhi);
  assign sts.slot_free   = !out_valid_r || out_tready;

  // Read the last tail on accept, then each midpoint
  assign rd_addr = cmd.load ? IDX_W'(used_count_r - CNT_W'(1)) : nmid;
  assign rd_en   = cmd.load || cmd.check || cmd.step;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.finish && !ovf_r) begin
      mem[lo_r] <= item_r;
    end
  end

  // Latch item, narrow bounds, settle the count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_tdata[mbqc_pkg::TRAIN_W-1:0];
      last_r <= in_tlast;
      used_r <= used_count_r;
      ovf_r  <= 1'b0;
    end
    if (cmd.check) begin
      if (need_new) begin
        if (full) begin
          ovf_r <= 1'b1;
          lo_r  <= '0;
        end else begin
          lo_r   <= IDX_W'(used_r);
          used_r <= used_r + CNT_W'(1);
        end
      end else begin
        lo_r  <= nlo;
        hi_r  <= nhi;
        mid_r <= nmid;
      end
    end
    if (cmd.step) begin
      lo_r  <= nlo;
      hi_r  <= nhi;
      mid_r <= nmid;
    end
    if (cmd.finish) begin
      out_idx_r  <= mbqc_pkg::QIDX_W'(lo_r);
      out_used_r <= mbqc_pkg::QUSED_W'(used_r);
      out_ovf_r  <= ovf_r;
    end
  end

  // Hold the count and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.finish) begin
        used_count_r <= last_r ? '0 : used_r;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{mbqc_pkg::OUT_PAD_W{1'b0}}, out_used_r, out_idx_r};
  assign out_tuser  = out_ovf_r;

endmodule

[rtl/core/mbqc_ctrl.sv]
// Controller: sequences accept, check, binary search and tail write-back
module mbqc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  mbqc_pkg::sts_t  sts,
  output mbqc_pkg::cmd_t  cmd
);

  mbqc_pkg::state_t state_r;
  mbqc_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mbqc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_tready  = 1'b0;
    case (state_r)
      mbqc_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = mbqc_pkg::ST_CHECK;
        end
      end
      mbqc_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.search_done ? mbqc_pkg::ST_WRITE : mbqc_pkg::ST_SEARCH;
      end
      mbqc_pkg::ST_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.search_done) begin
          state_nxt = mbqc_pkg::ST_WRITE;
        end
      end
      mbqc_pkg::ST_WRITE: begin
        if (sts.slot_free) begin
          cmd.finish = 1'b1;
          state_nxt  = mbqc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mbqc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/mbqc_checker.sv]
// Port checker of the minimum buffer queue counter, bound to the top level
`include "min_buffer_queue_counter_macros.svh"

module mbqc_prop_checker #(
  parameter int MAX_QUEUES = mbqc_pkg::DEF_MAX_QUEUES
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [mbqc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser
);

  localparam logic [mbqc_pkg::QUSED_W-1:0] FULL_CNT = mbqc_pkg::QUSED_W'(MAX_QUEUES);

  logic                             out_ovf;
  logic                             ovf_fields_ok;
  logic                             out_stall;
  logic [mbqc_pkg::OUT_TDATA_W:0]   out_word;

  // Decode the result fields seen on the port
  assign out_ovf       = out_tvalid && out_tuser;
  assign ovf_fields_ok = (out_tdata[mbqc_pkg::QIDX_LSB +: mbqc_pkg::QIDX_W] == '0) &&
                         (out_tdata[mbqc_pkg::QUSED_LSB +: mbqc_pkg::QUSED_W] == FULL_CNT);
  assign out_stall     = out_tvalid && !out_tready;
  assign out_word      = {out_tuser, out_tdata};

  // No result pending straight after reset
  `MBQC_ASSERT_RST(a_reset_idle, !out_tvalid, "result valid after reset")

  // One item at a time: no accept in the cycle after an accept
  `MBQC_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "back-to-back accept")

  // Overflow reports queue zero and a full count
  `MBQC_ASSERT_IMP(a_overflow_fields, out_ovf, ovf_fields_ok, "bad overflow result")

  // Hold a stalled result
  `MBQC_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_word), "result changed")

endmodule

bind min_buffer_queue_counter mbqc_prop_checker #(
  .MAX_QUEUES (MAX_QUEUES)
) u_mbqc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

[verif/mbqc_checker.sv]
`timescale 1ns / 100ps
// Checker of the minimum buffer queue counter: placement prediction and result comparison
module mbqc_checker #(
  parameter int MAX_QUEUES = mbqc_pkg::DEF_MAX_QUEUES
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  input  logic [mbqc_pkg::IN_TDATA_W-1:0]      in_tdata,   // [15:0] train_number
  input  logic                                 in_tlast,   // last_item
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [mbqc_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [5:0] queue_index, [12:6] queues_used
  input  logic                                 out_tuser,  // overflow
  output int                                   err_count,
  output int                                   pending
);

  localparam int TW  = mbqc_pkg::TRAIN_W;
  localparam int QIW = mbqc_pkg::QIDX_W;
  localparam int QUW = mbqc_pkg::QUSED_W;

  typedef struct packed {
    logic [QIW-1:0] qidx;
    logic [QUW-1:0] qused;
    logic           ovf;
  } placement_t;

  // Own copy of the queue tails and the count in use
  logic [TW-1:0] tails [MAX_QUEUES];
  int unsigned   used_q;

  placement_t placements_due [$];
  int         mismatches;

  // Place one train number, update the tails and return the expected result
  function automatic placement_t place_train(input logic [TW-1:0] num, input logic lastf);
    placement_t  res;
    int unsigned lo, hi, mid, idx;
    res = '0;
    idx = 0;
    if (used_q == 0 || tails[used_q-1] > num) begin
      // open a new queue, or drop the item when every queue is taken
      if (used_q < MAX_QUEUES) begin
        idx = used_q;
        tails[idx] = num;
        used_q++;
      end else begin
        res.ovf = 1'b1;
      end
    end else begin
      // binary search for the first tail not above the item
      lo = 0;
      hi = used_q;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (tails[mid] > num) lo = mid + 1;
        else hi = mid;
      end
      idx = lo;
      tails[idx] = num;
    end
    res.qidx  = QIW'(idx);
    res.qused = QUW'(used_q);
    if (lastf) used_q = 0;
    return res;
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mbqc mismatch: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    placement_t got, want;
    if (!rst_n) begin
      used_q = 0;
      placements_due.delete();
      mismatches = 0;
    end else begin
      // compare each delivered result with the oldest expectation
      if (out_tvalid && out_tready) begin
        got.qidx  = out_tdata[mbqc_pkg::QIDX_LSB +: QIW];
        got.qused = out_tdata[mbqc_pkg::QUSED_LSB +: QUW];
        got.ovf   = out_tuser;
        if (placements_due.size() == 0) begin
          note_error($sformatf("unexpected result qidx=%0d used=%0d ovf=%0b",
                               got.qidx, got.qused, got.ovf));
        end else begin
          want = placements_due.pop_front();
          if (got.qidx != want.qidx || got.qused != want.qused || got.ovf != want.ovf)
            note_error($sformatf("qidx exp %0d got %0d, used exp %0d got %0d, ovf exp %0b got %0b",
                                 want.qidx, got.qidx, want.qused, got.qused,
                                 want.ovf, got.ovf));
        end
      end
      // predict the result of each accepted item
      if (in_tvalid && in_tready)
        placements_due.push_back(place_train(in_tdata[TW-1:0], in_tlast));
    end
    err_count <= mismatches;
    pending   <= placements_due.size();
  end

endmodule

[verif/tb_min_buffer_queue_counter.sv]
`timescale 1ns / 100ps
// Testbench top of the minimum buffer queue counter: stimulus, handshake pacing and verdict
module tb_min_buffer_queue_counter;

  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEM_TARGET = 800;

  logic                                clk = 1'b0;
  logic                                rst_n;
  logic                                in_tvalid;
  logic                                in_tready;
  logic [mbqc_pkg::IN_TDATA_W-1:0]     in_tdata;   // [15:0] train_number
  logic                                in_tlast;   // last_item
  logic                                out_tvalid;
  logic                                out_tready;
  logic [mbqc_pkg::OUT_TDATA_W-1:0]    out_tdata;  // [5:0] queue_index, [12:6] queues_used
  logic                                out_tuser;  // overflow
  int                                  err_count;
  int                                  pending;

  int sent;
  int rx_count;
  int cycle_cnt;
  bit gapless;

  always #5 clk = ~clk;

  min_buffer_queue_counter uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  mbqc_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .err_count  (err_count),
    .pending    (pending)
  );

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic [15:0] num, input logic lastf);
    int gap;
    gap = gapless ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= num;
    in_tlast  <= lastf;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Stimulus
  initial begin
    int          kind, len, base, span;
    logic [15:0] v;
    bit          pause_done;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    sent       = 0;
    gapless    = 0;
    pause_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // single-item sequences at both extremes, cleared by last
    send_item(16'hFFFF, 1'b1);
    send_item(16'h0000, 1'b1);
    // equal values, new queues, searches into inner queues
    send_item(16'd100, 1'b0);
    send_item(16'd100, 1'b0);
    send_item(16'd50,  1'b0);
    send_item(16'd75,  1'b0);
    send_item(16'd200, 1'b0);
    send_item(16'd0,   1'b0);
    send_item(16'd0,   1'b1);
    // extremes mixed in one sequence, search lands in the middle
    send_item(16'hFFFF, 1'b0);
    send_item(16'hFFFE, 1'b0);
    send_item(16'h0001, 1'b0);
    send_item(16'h0000, 1'b0);
    send_item(16'h8000, 1'b0);
    send_item(16'hFFFF, 1'b1);

    // random sequences
    while (sent < ITEM_TARGET) begin
      gapless = ($urandom_range(0, 3) == 0);
      if (!pause_done && sent >= 400) begin
        wait_drained();
        pause_done = 1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        // unordered values across the full range
        len = $urandom_range(1, 24);
        for (int i = 0; i < len; i++) send_item(16'($urandom), i == len - 1);
      end else if (kind < 70) begin
        // few distinct values: many ties with the tails
        len  = $urandom_range(1, 30);
        base = $urandom_range(0, 65535 - 7);
        span = $urandom_range(0, 7);
        for (int i = 0; i < len; i++)
          send_item(16'(base + $urandom_range(0, span)), i == len - 1);
      end else if (kind < 82) begin
        // falling run long enough to take every queue and overflow
        len = $urandom_range(66, 80);
        v   = 16'hFFFF - 16'($urandom_range(0, 300));
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_item(16'($urandom_range(v, 16'hFFFF)), i == len - 1);
          end else begin
            send_item(v, i == len - 1);
            v = v - 16'($urandom_range(1, 750));
          end
        end
      end else if (kind < 92) begin
        // rising run: everything lands in the first queue
        len = $urandom_range(1, 20);
        v   = 16'($urandom_range(0, 1000));
        for (int i = 0; i < len; i++) begin
          send_item(v, i == len - 1);
          v = v + 16'($urandom_range(0, 900));
        end
      end else begin
        // stray item, last at random
        send_item(16'($urandom), 1'($urandom_range(0, 1)));
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_min_buffer_queue_counter: done, clean");
    end else begin
      $display("tb_min_buffer_queue_counter: done, errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back the block up
  initial begin
    int  stall;
    bit  rx_burst;
    out_tready <= 1'b0;
    rx_count = 0;
    rx_burst = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (rx_count % 50 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (rx_count == 300) stall = 400;
      else if (rx_burst) stall = 0;
      else stall = pick_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      rx_count++;
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_min_buffer_queue_counter: done, errors");
    $finish;
  end

endmodule
